[hdl/bmm_pkg.sv]
// Shared types and constants for the block matrix multiply core.
package bmm_pkg;

  localparam int DimW     = 4;
  localparam int IdxW     = 3;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int AccW     = ProdW + IdxW;
  localparam int FracBits = 16;
  localparam int CfgIdxW  = 2;

  localparam logic [1:0] OpWriteA  = 2'd0;
  localparam logic [1:0] OpWriteB  = 2'd1;
  localparam logic [1:0] OpCompute = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgRowsOfA  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInnerSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgColsOfB  = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [DataW-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         out_row;
    logic [IdxW-1:0]         out_col;
    logic signed [DataW-1:0] out_value;
    logic                    last;
  } out_item_t;

  // Effective sizes, already clamped to 1..MAX_DIM.
  typedef struct packed {
    logic [DimW-1:0] m;
    logic [DimW-1:0] n;
    logic [DimW-1:0] p;
  } dims_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] k;
    logic [IdxW-1:0] col;
    logic            first;
    logic            dot_last;
    logic            elem_last;
  } cmd_t;

  typedef struct packed {
    logic out_fire;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

endpackage

[hdl/bmm_ctrl.sv]
// Sequencer that walks the result elements and the dot-product terms.
module bmm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmm_pkg::dims_t    dims_i,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  input  bmm_pkg::status_t  status_i,
  output bmm_pkg::cmd_t     cmd_o
);
  import bmm_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            k_end, j_end, i_end;

  assign k_end = ({1'b0, k_q} == dims_i.n - DimW'(1));
  assign j_end = ({1'b0, j_q} == dims_i.p - DimW'(1));
  assign i_end = ({1'b0, i_q} == dims_i.m - DimW'(1));

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.rd_en     = (state_q == ST_ISSUE);
    cmd_o.row       = i_q;
    cmd_o.k         = k_q;
    cmd_o.col       = j_q;
    cmd_o.first     = (k_q == '0);
    cmd_o.dot_last  = k_end;
    cmd_o.elem_last = i_end && j_end;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_op_i == OpCompute) begin
          state_d = ST_ISSUE;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (k_end) begin
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      ST_WAIT: begin
        // hold until the finished element is taken, then advance
        if (status_i.out_fire) begin
          k_d = '0;
          if (i_end && j_end) begin
            state_d = ST_IDLE;
          end else if (j_end) begin
            state_d = ST_ISSUE;
            j_d     = '0;
            i_d     = i_q + IdxW'(1);
          end else begin
            state_d = ST_ISSUE;
            j_d     = j_q + IdxW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

endmodule

[hdl/bmm_datapath.sv]
// Operand memories, multiply-accumulate pipeline and result register.
module bmm_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmm_pkg::dims_t      dims_i,
  input  logic                in_fire_i,
  input  bmm_pkg::in_item_t   in_data_i,
  input  bmm_pkg::cmd_t       cmd_i,
  output bmm_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmm_pkg::out_item_t  out_data_o
);
  import bmm_pkg::*;

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic            dot_last;
    logic            elem_last;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } tag_t;

  function automatic logic [AddrW-1:0] addr_of(logic [IdxW-1:0] r, logic [IdxW-1:0] c);
    int a;
    a = int'(r) * MAX_DIM + int'(c);
    return a[AddrW-1:0];
  endfunction

  logic [DataW-1:0] mem_a [Depth];
  logic [DataW-1:0] mem_b [Depth];

  logic             we_a, we_b;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;

  logic [DataW-1:0]        a_rd_q, b_rd_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d, sh;
  tag_t                    tag1_q, tag2_q, tag3_q, tag0;

  logic        out_valid_q;
  out_item_t   out_q;
  logic [DataW-1:0] sat_val;

  assign waddr = addr_of(in_data_i.row_index, in_data_i.col_index);
  assign we_a  = in_fire_i && in_data_i.op == OpWriteA
              && {1'b0, in_data_i.row_index} < dims_i.m
              && {1'b0, in_data_i.col_index} < dims_i.n;
  assign we_b  = in_fire_i && in_data_i.op == OpWriteB
              && {1'b0, in_data_i.row_index} < dims_i.n
              && {1'b0, in_data_i.col_index} < dims_i.p;

  assign raddr_a = addr_of(cmd_i.row, cmd_i.k);
  assign raddr_b = addr_of(cmd_i.k, cmd_i.col);

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr] <= in_data_i.element_value;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[waddr] <= in_data_i.element_value;
    end
    if (cmd_i.rd_en) begin
      b_rd_q <= mem_b[raddr_b];
    end
  end

  always_comb begin
    tag0.valid     = cmd_i.rd_en;
    tag0.first     = cmd_i.first;
    tag0.dot_last  = cmd_i.dot_last;
    tag0.elem_last = cmd_i.elem_last;
    tag0.row       = cmd_i.row;
    tag0.col       = cmd_i.col;
  end

  assign acc_d = (tag2_q.first ? '0 : acc_q) + AccW'(prod_q);

  // Shift right arithmetically, then clamp to the 32-bit range.
  assign sh = acc_q >>> FracBits;
  always_comb begin
    if (&sh[AccW-1:DataW-1] || ~|sh[AccW-1:DataW-1]) begin
      sat_val = sh[DataW-1:0];
    end else if (sh[AccW-1]) begin
      sat_val = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      tag3_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag1_q <= tag0;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      if (tag3_q.valid && tag3_q.dot_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) begin
      prod_q <= $signed(a_rd_q) * $signed(b_rd_q);
    end
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag3_q.valid && tag3_q.dot_last) begin
      out_q.out_row   <= tag3_q.row;
      out_q.out_col   <= tag3_q.col;
      out_q.out_value <= sat_val;
      out_q.last      <= tag3_q.elem_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.out_fire = out_valid_q && out_ready_i;

endmodule

[hdl/block_matrix_multiply_core.sv]
// Top level of the block matrix multiply core: size registers, sequencer, datapath.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): op 0 writes an element
// of A, op 1 writes an element of B at (row_index, col_index); writes outside
// the configured sizes are dropped. Op 2 computes C = A * B and emits every
// element of C in row-major order on the output channel, with last set on
// the final one. Op 3 is consumed and does nothing.
// Loads are taken one per cycle while no compute is running.
// A compute transaction runs m * p elements; each element takes n memory reads
// into the single multiply-accumulate unit, which passes each term through the
// product and accumulator registers into the saturating result register.
// One element is in flight at a time: a stalled receiver holds the result
// register and the sequencer waits.
// The input channel is closed from compute acceptance until the last result
// is taken. Reset sets all three sizes to 8 and empties the pipeline; the
// operand memories are not cleared and must be written before they are read.
// Size registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i;
// the user must write them only while the block is idle, and the block itself
// does not enforce this; a size of 0 acts as 1, above MAX_DIM as MAX_DIM.
module block_matrix_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmm_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmm_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bmm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bmm_pkg::DimW-1:0]       cfg_wdata_i
);
  import bmm_pkg::*;

  logic [DimW-1:0] rows_q, inner_q, cols_q;
  dims_t           dims;
  cmd_t            cmd;
  status_t         status;
  logic            in_fire;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DimW'(8);
      inner_q <= DimW'(8);
      cols_q  <= DimW'(8);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRowsOfA:   rows_q  <= cfg_wdata_i;
        CfgInnerSize: inner_q <= cfg_wdata_i;
        CfgColsOfB:   cols_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.m = clamp_dim(rows_q);
    dims.n = clamp_dim(inner_q);
    dims.p = clamp_dim(cols_q);
  end

  assign in_fire = in_valid_i && in_ready_o;

  bmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dims_i     (dims),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .in_fire_i   (in_fire),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
